[hw/rtl/assert_macros.svh]
// Assertion macros shared by the sorter RTL.
// Each macro assumes signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/iss_pkg.sv]
`timescale 1ns / 1ps
// Package for the insertion sorter: payload types, cell link types, state codes.
// No dependencies.
package iss_pkg;

    localparam int DATA_W = 32;
    localparam int CMP_W  = 11;
    localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic [CMP_W-1:0] cmp_t;

    // Data and compare flags handed from one cell to the next
    typedef struct packed {
        value_t val;
        logic   gt;
        logic   le;
    } link_t;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   shift;
        value_t value;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

endpackage

[hw/rtl/iss_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sorter input items and sorted results.
// Depends on iss_pkg.
interface iss_item_if;
    import iss_pkg::*;
    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

interface iss_result_if;
    import iss_pkg::*;
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   final_res;
    cmp_t   comparisons;
    logic   overflow;

    modport source (output valid, output sorted_value, output final_res,
                    output comparisons, output overflow, input ready);
    modport sink (input valid, input sorted_value, input final_res,
                  input comparisons, input overflow, output ready);
endinterface

[hw/rtl/iss_cell.sv]
`timescale 1ns / 1ps
// One cell of the insertion chain: holds one element, compares it with the
// incoming value and shifts up on insert or down on emission. Depends on iss_pkg.
module iss_cell (
    input  logic               clk,
    input  iss_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  iss_pkg::link_t     prev,
    input  iss_pkg::value_t    next_val,
    output iss_pkg::link_t     link,
    output logic               ins
);
    import iss_pkg::*;

    value_t val_reg;
    value_t val_next;
    logic   gt;
    logic   le;

    // Compare held element against the incoming value
    assign gt = occupied && (val_reg > ctrl.value);
    assign le = occupied && !gt;

    // Insertion point: the neighbor below stays, this one moves or is free
    assign ins = prev.le && !le;

    assign link.val = val_reg;
    assign link.gt  = gt;
    assign link.le  = le;

    // Shift down on emission, shift up or take the new value on insert
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.shift)
        begin
            val_next = next_val;
        end
        else if (ctrl.insert && prev.gt)
        begin
            val_next = prev.val;
        end
        else if (ctrl.insert && ins)
        begin
            val_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[hw/rtl/iss_cmp_acc.sv]
`timescale 1ns / 1ps
// Comparison accumulator: turns each insert's fill count and insertion point
// into a comparison count and adds it to a saturating total. Depends on iss_pkg.
module iss_cmp_acc #(
    parameter int CNT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stb,
    input  logic [CNT_W-1:0] count,
    input  logic [CNT_W-1:0] pos,
    input  logic             clear,
    output iss_pkg::cmp_t    total
);
    import iss_pkg::*;

    logic             pend_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] pos_reg;
    cmp_t             total_reg;
    cmp_t             total_next;
    logic [CMP_W:0]   sum;

    // Register one insert's figures ahead of the add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= stb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stb)
        begin
            cnt_reg <= count;
            pos_reg <= pos;
        end
    end

    // Shifted elements plus one when the scan stops above the bottom
    always_comb
    begin
        sum = {1'b0, total_reg} + (CMP_W+1)'(cnt_reg - pos_reg)
            + (CMP_W+1)'(pos_reg != '0);
        total_next = total_reg;
        if (clear)
        begin
            total_next = '0;
        end
        else if (pend_reg)
        begin
            total_next = sum[CMP_W] ? CMP_MAX : sum[CMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

[hw/rtl/insertion_sorter_with_compare_count.sv]
`timescale 1ns / 1ps
// Insertion sorter top level: cell chain, fill count, emission control.
// Depends on iss_pkg, iss_ifs, iss_cell, iss_cmp_acc, assert_macros.svh.
//
//  channel   dir  payload                                          transaction
//  items     in   value[31:0] signed, last                         valid & ready
//  results   out  sorted_value[31:0] signed, final_res,            valid & ready
//                 comparisons[10:0], overflow
//
// Items load back to back: every cell compares and shifts in parallel.
// After the last item, a drain state settles the comparison total, then one result
// per cycle leaves cell 0 while results.ready is high.
// Items are refused from the last item until the final result is registered.
// Reset clears the fill count, total, overflow flag and output valid at once.
// A stalled output holds its result and the chain waits.
module insertion_sorter_with_compare_count #(
    parameter int MAX_LEN = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    iss_item_if.sink            items,
    iss_result_if.source        results
);
    import iss_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             flag_reg;
    logic             flag_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    value_t           out_val_reg;
    logic             out_final_reg;
    cmp_t             out_cmp_reg;
    logic             out_ovf_reg;

    logic             accept;
    logic             full;
    logic             insert;
    logic             drop;
    logic             load;
    logic             final_one;
    cell_ctrl_t       ctrl;
    link_t            links [MAX_LEN];
    logic [MAX_LEN-1:0] ins_vec;
    logic [MAX_LEN-1:0] occ_vec;
    logic [CNT_W-1:0] pos;
    cmp_t             total;

    assign accept    = items.valid && items.ready;
    assign full      = count_reg == CNT_W'(MAX_LEN);
    assign insert    = accept && !full;
    assign drop      = accept && full;
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready);
    assign final_one = count_reg == CNT_W'(1);

    assign items.ready = state_reg == ST_LOAD;

    assign ctrl.insert = insert;
    assign ctrl.shift  = load;
    assign ctrl.value  = items.value;

    // Build the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++)
        begin : g_cell
            link_t  prev_link;
            value_t next_v;

            if (gi == 0)
            begin : g_bottom
                assign prev_link = '{val: '0, gt: 1'b0, le: 1'b1};
            end
            else
            begin : g_mid
                assign prev_link = links[gi-1];
            end

            if (gi == MAX_LEN - 1)
            begin : g_top
                assign next_v = '0;
            end
            else
            begin : g_below
                assign next_v = links[gi+1].val;
            end

            assign occ_vec[gi] = count_reg > CNT_W'(gi);

            iss_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occupied (occ_vec[gi]),
                .prev     (prev_link),
                .next_val (next_v),
                .link     (links[gi]),
                .ins      (ins_vec[gi])
            );
        end
    endgenerate

    // Encode the insertion point
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (ins_vec[i])
            begin
                pos = pos | CNT_W'(i);
            end
        end
    end

    iss_cmp_acc #(
        .CNT_W (CNT_W)
    ) u_cmp_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .stb   (insert),
        .count (count_reg),
        .pos   (pos),
        .clear (load && final_one),
        .total (total)
    );

    // Advance the load / drain / emit sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && items.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && final_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Track fill count and dropped items
    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        if (insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (load)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (drop)
        begin
            flag_next = 1'b1;
        end
        else if (load && final_one)
        begin
            flag_next = 1'b0;
        end
    end

    // Hold result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_val_reg   <= links[0].val;
            out_final_reg <= final_one;
            out_cmp_reg   <= final_one ? total : '0;
            out_ovf_reg   <= flag_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_val_reg;
    assign results.final_res    = out_final_reg;
    assign results.comparisons  = out_cmp_reg;
    assign results.overflow     = out_ovf_reg;

    `ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_LEN))
    `ASSERT_IMPLIES(a_one_insert_point, insert, $onehot(ins_vec))
    `ASSERT_NEXT(a_drop_sets_flag, drop, flag_reg)
    `ASSERT_IMPLIES(a_emit_nonempty, state_reg == ST_EMIT, count_reg != '0)
    `ASSERT_NEXT(a_final_empties, load && final_one, (state_reg == ST_LOAD) && (count_reg == '0))

endmodule
